FILE: rtl/core/ncc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared widths, command codes, controller states and control bundles of the
// nearest centroid classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

	localparam int FEAT_W     = 16;
	localparam int SUM_W      = 26;
	localparam int CNT_W      = 10;
	localparam int CLS_W      = 3;
	localparam int OP_W       = 2;
	localparam int MAXS_W     = 16;
	localparam int SQ_W       = 2 * SUM_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int OUT_DIST_W = 33;
	localparam int DIVC_W     = $clog2(SUM_W);

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_TRAIN = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DIFF,
		ST_MULT,
		ST_ACC,
		ST_DONE
	} ncc_state_t;

	typedef struct packed {
		logic clear;
		logic train;
		logic query_start;
		logic load_class;
		logic div_step;
		logic diff;
		logic mult;
		logic acc;
		logic next_class;
		logic result_load;
	} ncc_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic last_class;
	} ncc_sts_t;

endpackage

FILE: rtl/core/ncc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_div
// Restoring divider, one quotient bit per step: class sum over sample count.
// ----------------------------------------------------------------------------
module ncc_div (
	input  logic                      clk,
	input  logic                      start,
	input  logic                      step,
	input  logic [ncc_pkg::SUM_W-1:0] dividend,
	input  logic [ncc_pkg::CNT_W-1:0] divisor,
	output logic [ncc_pkg::SUM_W-1:0] quotient
);
	import ncc_pkg::*;

	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   trial_sub;
	logic             ge;

	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign ge        = trial >= {1'b0, divisor};
	assign trial_sub = trial - {1'b0, divisor};
	assign quotient  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

endmodule

FILE: rtl/core/ncc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_datapath
// Per-class sums and counts, centroid dividers, distance stages, running
// minimum and the result register.
// ----------------------------------------------------------------------------
module ncc_datapath #(
	parameter int NUM_CLASSES = 8,
	parameter int MAX_SAMPLES = 1023
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ncc_pkg::ncc_cmd_t              cmd_ctl,
	output ncc_pkg::ncc_sts_t              sts,
	input  logic [ncc_pkg::FEAT_W-1:0]     height,
	input  logic [ncc_pkg::FEAT_W-1:0]     weight,
	input  logic [ncc_pkg::CLS_W-1:0]      class_id,
	output logic [ncc_pkg::CLS_W-1:0]      predicted_class,
	output logic [ncc_pkg::OUT_DIST_W-1:0] min_dist_sq,
	output logic                           found
);
	import ncc_pkg::*;

	localparam int NC  = (NUM_CLASSES < (1 << CLS_W)) ? NUM_CLASSES : (1 << CLS_W);
	localparam int CIW = $clog2(NC);
	localparam logic [MAXS_W-1:0] MAX_S   = MAXS_W'(MAX_SAMPLES);
	localparam logic [CLS_W:0]    NC_LIM  = (CLS_W + 1)'(NC);
	localparam logic [CIW-1:0]    LAST_IX = CIW'(NC - 1);

	logic [SUM_W-1:0] hsum_q [NC];
	logic [SUM_W-1:0] wsum_q [NC];
	logic [CNT_W-1:0] cnt_q  [NC];

	logic [CIW-1:0]    k_q;
	logic [CIW-1:0]    rd_idx;
	logic [SUM_W-1:0]  hsum_rd;
	logic [SUM_W-1:0]  wsum_rd;
	logic [CNT_W-1:0]  cnt_rd;
	logic              class_ok;
	logic              cnt_ok;
	logic [FEAT_W-1:0] qh_q;
	logic [FEAT_W-1:0] qw_q;
	logic [SUM_W-1:0]  ch;
	logic [SUM_W-1:0]  cw;
	logic [SUM_W-1:0]  qh_ext;
	logic [SUM_W-1:0]  qw_ext;
	logic [SUM_W-1:0]  dh_s1;
	logic [SUM_W-1:0]  dw_s1;
	logic [SQ_W-1:0]   sqh_s2;
	logic [SQ_W-1:0]   sqw_s2;
	logic [DIST_W-1:0] dist_sq;
	logic [DIST_W-1:0] best_d_q;
	logic [CIW-1:0]    best_cls_q;
	logic              any_q;

	logic [CLS_W-1:0]      res_cls_q;
	logic [OUT_DIST_W-1:0] res_dist_q;
	logic                  res_found_q;

	assign rd_idx   = cmd_ctl.train ? class_id[CIW-1:0] : k_q;
	assign hsum_rd  = hsum_q[rd_idx];
	assign wsum_rd  = wsum_q[rd_idx];
	assign cnt_rd   = cnt_q[rd_idx];
	assign class_ok = {1'b0, class_id} < NC_LIM;
	assign cnt_ok   = MAXS_W'(cnt_rd) < MAX_S;

	assign sts.count_zero = (cnt_q[k_q] == '0);
	assign sts.last_class = (k_q == LAST_IX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				hsum_q[i] <= '0;
				wsum_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < NC; i++) begin
				if (cmd_ctl.clear) begin
					hsum_q[i] <= '0;
					wsum_q[i] <= '0;
					cnt_q[i]  <= '0;
				end else if (cmd_ctl.train && class_ok && cnt_ok && rd_idx == CIW'(i)) begin
					hsum_q[i] <= hsum_q[i] + SUM_W'(height);
					wsum_q[i] <= wsum_q[i] + SUM_W'(weight);
					cnt_q[i]  <= cnt_q[i] + CNT_W'(1);
				end
			end
		end
	end

	ncc_div u_div_h (
		.clk      (clk),
		.start    (cmd_ctl.load_class),
		.step     (cmd_ctl.div_step),
		.dividend (hsum_rd),
		.divisor  (cnt_rd),
		.quotient (ch)
	);

	ncc_div u_div_w (
		.clk      (clk),
		.start    (cmd_ctl.load_class),
		.step     (cmd_ctl.div_step),
		.dividend (wsum_rd),
		.divisor  (cnt_rd),
		.quotient (cw)
	);

	assign qh_ext  = SUM_W'(qh_q);
	assign qw_ext  = SUM_W'(qw_q);
	assign dist_sq = DIST_W'(sqh_s2) + DIST_W'(sqw_s2);

	always_ff @(posedge clk) begin
		if (cmd_ctl.query_start) begin
			qh_q <= height;
			qw_q <= weight;
		end
		if (cmd_ctl.diff) begin
			dh_s1 <= (ch >= qh_ext) ? ch - qh_ext : qh_ext - ch;
			dw_s1 <= (cw >= qw_ext) ? cw - qw_ext : qw_ext - cw;
		end
		if (cmd_ctl.mult) begin
			sqh_s2 <= SQ_W'(dh_s1) * SQ_W'(dh_s1);
			sqw_s2 <= SQ_W'(dw_s1) * SQ_W'(dw_s1);
		end
		if (cmd_ctl.result_load) begin
			res_cls_q   <= CLS_W'(best_cls_q);
			res_dist_q  <= best_d_q[OUT_DIST_W-1:0];
			res_found_q <= any_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			best_d_q   <= '0;
			best_cls_q <= '0;
			any_q      <= 1'b0;
		end else if (cmd_ctl.query_start) begin
			k_q        <= '0;
			best_d_q   <= '0;
			best_cls_q <= '0;
			any_q      <= 1'b0;
		end else begin
			if (cmd_ctl.acc && (!any_q || dist_sq < best_d_q)) begin
				best_d_q   <= dist_sq;
				best_cls_q <= k_q;
				any_q      <= 1'b1;
			end
			if (cmd_ctl.next_class) begin
				k_q <= k_q + CIW'(1);
			end
		end
	end

	assign predicted_class = res_cls_q;
	assign min_dist_sq     = res_dist_q;
	assign found           = res_found_q;

endmodule

FILE: rtl/core/ncc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_ctrl
// Sequencer: decodes commands, walks the classes of a query through divide,
// difference, square and compare, and drives the result handshake.
// ----------------------------------------------------------------------------
module ncc_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ncc_pkg::OP_W-1:0] cmd,
	output logic                     out_valid,
	input  logic                     out_stall,
	output ncc_pkg::ncc_cmd_t        cmd_ctl,
	input  ncc_pkg::ncc_sts_t        sts
);
	import ncc_pkg::*;

	ncc_state_t        state_q;
	ncc_state_t        state_d;
	logic [DIVC_W-1:0] div_cnt_q;
	logic              out_valid_q;
	logic              out_free;
	logic              div_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_last  = (div_cnt_q == DIVC_W'(SUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_ctl.load_class) begin
				div_cnt_q <= '0;
			end else if (cmd_ctl.div_step) begin
				div_cnt_q <= div_cnt_q + DIVC_W'(1);
			end
			if (cmd_ctl.result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd)
						OP_CLEAR: cmd_ctl.clear = 1'b1;
						OP_TRAIN: cmd_ctl.train = 1'b1;
						OP_QUERY: begin
							cmd_ctl.query_start = 1'b1;
							state_d             = ST_LOAD;
						end
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				if (!sts.count_zero) begin
					cmd_ctl.load_class = 1'b1;
					state_d            = ST_DIV;
				end else if (sts.last_class) begin
					state_d = ST_DONE;
				end else begin
					cmd_ctl.next_class = 1'b1;
				end
			end
			ST_DIV: begin
				cmd_ctl.div_step = 1'b1;
				if (div_last) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd_ctl.diff = 1'b1;
				state_d      = ST_MULT;
			end
			ST_MULT: begin
				cmd_ctl.mult = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd_ctl.acc = 1'b1;
				if (sts.last_class) begin
					state_d = ST_DONE;
				end else begin
					cmd_ctl.next_class = 1'b1;
					state_d            = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd_ctl.result_load = 1'b1;
					state_d             = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/core/nearest_centroid_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier
// Minimum distance classifier over height and weight in unsigned Q12.4.
//
// Input channel (in_valid/in_stall) carries one command word: clear, train or
// query. Clear and train give no result; cmd 3 is ignored.
// A query gives exactly one result word on the output channel
// (out_valid/out_stall): nearest class, squared distance in Q25.8, found.
// A query walks every class and skips the empty ones; for each trained class
// the centroid dividers produce one quotient bit per cycle.
// in_stall stays high from the query until its result is in the output
// register. The output register holds its word while out_stall is high; the
// block still takes clear and train words meanwhile, and a following query
// waits at its end for the register to free.
// Reset empties every class and drops any pending result.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier #(
	parameter int NUM_CLASSES = 8,
	parameter int MAX_SAMPLES = 1023
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ncc_pkg::OP_W-1:0]       cmd,
	input  logic [ncc_pkg::FEAT_W-1:0]     height,
	input  logic [ncc_pkg::FEAT_W-1:0]     weight,
	input  logic [ncc_pkg::CLS_W-1:0]      class_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ncc_pkg::CLS_W-1:0]      predicted_class,
	output logic [ncc_pkg::OUT_DIST_W-1:0] min_dist_sq,
	output logic                           found
);
	import ncc_pkg::*;

	ncc_cmd_t cmd_ctl;
	ncc_sts_t sts;

	ncc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd_ctl   (cmd_ctl),
		.sts       (sts)
	);

	ncc_datapath #(
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_ctl         (cmd_ctl),
		.sts             (sts),
		.height          (height),
		.weight          (weight),
		.class_id        (class_id),
		.predicted_class (predicted_class),
		.min_dist_sq     (min_dist_sq),
		.found           (found)
	);

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> predicted_class == '0 && min_dist_sq == '0)
		else $error("empty result carries nonzero class or distance");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == OP_QUERY |=> in_stall)
		else $error("query accepted without entering busy");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in progress");

endmodule
